// ----- src/bta_pkg.sv -----
// Shared types, constants and the arctangent table for the bearing and turn angle block.
package bta_pkg;

	localparam int COORD_WIDTH     = 16;
	localparam int DIFF_WIDTH      = COORD_WIDTH + 1;
	localparam int ANGLE_FRAC_BITS = 7;
	localparam int ANGLE_WIDTH     = ANGLE_FRAC_BITS + 9;
	localparam int ZFRAC           = 20;
	localparam int ZW              = 28;
	localparam int ROUND_SHIFT     = ZFRAC - ANGLE_FRAC_BITS;

	localparam logic [ANGLE_WIDTH:0] DEG_90  = (ANGLE_WIDTH + 1)'(90)  << ANGLE_FRAC_BITS;
	localparam logic [ANGLE_WIDTH:0] DEG_180 = (ANGLE_WIDTH + 1)'(180) << ANGLE_FRAC_BITS;
	localparam logic [ANGLE_WIDTH:0] DEG_270 = (ANGLE_WIDTH + 1)'(270) << ANGLE_FRAC_BITS;
	localparam logic [ANGLE_WIDTH:0] DEG_360 = (ANGLE_WIDTH + 1)'(360) << ANGLE_FRAC_BITS;
	localparam logic signed [ZW-1:0] Z_MAX   = ZW'(90) << ZFRAC;

	// quadrant of (dx, dy), both nonzero
	localparam logic [1:0] QUAD_PP = 2'd0;
	localparam logic [1:0] QUAD_NP = 2'd1;
	localparam logic [1:0] QUAD_NN = 2'd2;
	localparam logic [1:0] QUAD_PN = 2'd3;

	typedef struct packed {
		logic signed [COORD_WIDTH-1:0] start_x;
		logic signed [COORD_WIDTH-1:0] start_y;
		logic signed [COORD_WIDTH-1:0] target_x;
		logic signed [COORD_WIDTH-1:0] target_y;
		logic        [ANGLE_WIDTH-1:0] heading;
	} bta_item_t;

	typedef struct packed {
		logic        [ANGLE_WIDTH-1:0] bearing;
		logic signed [ANGLE_WIDTH-1:0] turn_angle;
	} bta_result_t;

	// what rides alongside the CORDIC pipe
	typedef struct packed {
		logic                   spec;
		logic [1:0]             quad;
		logic [ANGLE_WIDTH-1:0] spec_bearing;
		logic [ANGLE_WIDTH-1:0] heading;
	} bta_side_t;

	// atan(2^-i) in degrees times 2^20, rounded
	function automatic logic [ZW-1:0] atan_deg(input int i);
		logic [ZW-1:0] t;
		unique case (i)
			0:  t = ZW'(47185920);
			1:  t = ZW'(27855475);
			2:  t = ZW'(14718068);
			3:  t = ZW'(7471121);
			4:  t = ZW'(3750058);
			5:  t = ZW'(1876857);
			6:  t = ZW'(938658);
			7:  t = ZW'(469357);
			8:  t = ZW'(234682);
			9:  t = ZW'(117342);
			10: t = ZW'(58671);
			11: t = ZW'(29335);
			12: t = ZW'(14668);
			13: t = ZW'(7334);
			14: t = ZW'(3667);
			15: t = ZW'(1833);
			16: t = ZW'(917);
			17: t = ZW'(458);
			18: t = ZW'(229);
			19: t = ZW'(115);
			20: t = ZW'(57);
			21: t = ZW'(29);
			22: t = ZW'(14);
			23: t = ZW'(7);
			default: t = '0;
		endcase
		return t;
	endfunction

endpackage

// ----- src/bta_cordic.sv -----
// CORDIC vectoring pipeline: one registered micro-rotation per stage, side data alongside.
module bta_cordic
	import bta_pkg::*;
#(
	parameter int STEPS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  vld_in,
	input  bta_side_t             side_in,
	input  logic [DIFF_WIDTH-1:0] ax,
	input  logic [DIFF_WIDTH-1:0] ay,
	output logic                  vld_out,
	output bta_side_t             side_out,
	output logic signed [ZW-1:0]  z_out
);

	// room for the input shift, the CORDIC gain and the sign
	localparam int XW = STEPS + DIFF_WIDTH + 3;

	logic signed [XW-1:0] x_s [0:STEPS];
	logic signed [XW-1:0] y_s [0:STEPS];
	logic signed [ZW-1:0] z_s [0:STEPS];
	bta_side_t            side_s [0:STEPS];
	logic                 vld_s  [0:STEPS];

	assign x_s[0]    = $signed(XW'(ax)) <<< STEPS;
	assign y_s[0]    = $signed(XW'(ay)) <<< STEPS;
	assign z_s[0]    = '0;
	assign side_s[0] = side_in;
	assign vld_s[0]  = vld_in;

	for (genvar i = 0; i < STEPS; i++) begin : g_step
		localparam logic signed [ZW-1:0] T = $signed(atan_deg(i));
		logic signed [XW-1:0] xs;
		logic signed [XW-1:0] ys;

		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i+1] <= 1'b0;
			end else begin
				vld_s[i+1] <= vld_s[i];
			end
		end

		// rotate toward the x axis, using the previous stage's x and y
		always_ff @(posedge clk) begin
			side_s[i+1] <= side_s[i];
			if (!y_s[i][XW-1]) begin
				x_s[i+1] <= x_s[i] + ys;
				y_s[i+1] <= y_s[i] - xs;
				z_s[i+1] <= z_s[i] + T;
			end else begin
				x_s[i+1] <= x_s[i] - ys;
				y_s[i+1] <= y_s[i] + xs;
				z_s[i+1] <= z_s[i] - T;
			end
		end
	end

	assign vld_out  = vld_s[STEPS];
	assign side_out = side_s[STEPS];
	assign z_out    = z_s[STEPS];

endmodule

// ----- src/bearing_and_turn_angle.sv -----
// Top level: bearing from start to target and turn angle relative to the heading.
// Pipeline: one register stage per CORDIC micro-rotation plus two front
// and three back stages between the start edge and the done strobe.
// Throughput: one word per cycle; busy stays low and results cannot be held off.
// Reset clears only the valid bits; a word in flight at reset is dropped.
module bearing_and_turn_angle
	import bta_pkg::*;
#(
	parameter int CORDIC_STEPS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  bta_item_t   item,
	output logic        busy,
	output logic        done,
	output bta_result_t result
);

	// front stage 1: differences
	logic                         vld_s1;
	logic signed [DIFF_WIDTH-1:0] dx_s1;
	logic signed [DIFF_WIDTH-1:0] dy_s1;
	logic [ANGLE_WIDTH-1:0]       heading_s1;

	// front stage 2: magnitudes and classification
	logic                  vld_s2;
	logic [DIFF_WIDTH-1:0] ax_s2;
	logic [DIFF_WIDTH-1:0] ay_s2;
	bta_side_t             side_s2;

	// CORDIC output
	logic                 cvld;
	bta_side_t            cside;
	logic signed [ZW-1:0] cz;

	// back stages
	logic                   vld_s3;
	bta_side_t              side_s3;
	logic [ANGLE_WIDTH-1:0] a_s3;
	logic                   vld_s4;
	logic [ANGLE_WIDTH-1:0] bearing_s4;
	logic [ANGLE_WIDTH-1:0] heading_s4;
	logic                   vld_s5;
	bta_result_t            res_s5;

	logic                   take;
	bta_side_t              side_n;
	logic signed [ZW-1:0]   zc;
	logic [ZW-1:0]          zr;
	logic [ANGLE_WIDTH:0]   bq;
	logic [ANGLE_WIDTH:0]   bw;
	logic signed [ANGLE_WIDTH+1:0] d0;
	logic signed [ANGLE_WIDTH+1:0] dw;

	localparam logic signed [ANGLE_WIDTH+1:0] D180 = $signed((ANGLE_WIDTH + 2)'(DEG_180));
	localparam logic signed [ANGLE_WIDTH+1:0] D360 = $signed((ANGLE_WIDTH + 2)'(DEG_360));

	assign busy = 1'b0;
	assign take = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= take;
			vld_s2 <= vld_s1;
			vld_s3 <= cvld;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		dx_s1      <= DIFF_WIDTH'(item.target_x) - DIFF_WIDTH'(item.start_x);
		dy_s1      <= DIFF_WIDTH'(item.target_y) - DIFF_WIDTH'(item.start_y);
		heading_s1 <= item.heading;
	end

	// points on an axis bypass the arctangent
	always_comb begin
		side_n.heading = heading_s1;
		side_n.spec    = (dx_s1 == '0) || (dy_s1 == '0);
		priority if (dx_s1 == '0 && dy_s1 == '0) begin
			side_n.spec_bearing = '0;
		end else if (dx_s1 == '0) begin
			side_n.spec_bearing = dy_s1[DIFF_WIDTH-1] ? DEG_270[ANGLE_WIDTH-1:0]
			                                          : DEG_90[ANGLE_WIDTH-1:0];
		end else if (dy_s1 == '0) begin
			side_n.spec_bearing = dx_s1[DIFF_WIDTH-1] ? DEG_180[ANGLE_WIDTH-1:0] : '0;
		end else begin
			side_n.spec_bearing = '0;
		end
		unique case ({dx_s1[DIFF_WIDTH-1], dy_s1[DIFF_WIDTH-1]})
			2'b00: side_n.quad = QUAD_PP;
			2'b10: side_n.quad = QUAD_NP;
			2'b11: side_n.quad = QUAD_NN;
			2'b01: side_n.quad = QUAD_PN;
			default: side_n.quad = QUAD_PP;
		endcase
	end

	always_ff @(posedge clk) begin
		ax_s2   <= dx_s1[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx_s1) : DIFF_WIDTH'(dx_s1);
		ay_s2   <= dy_s1[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy_s1) : DIFF_WIDTH'(dy_s1);
		side_s2 <= side_n;
	end

	bta_cordic #(
		.STEPS(CORDIC_STEPS)
	) u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_s2),
		.side_in (side_s2),
		.ax      (ax_s2),
		.ay      (ay_s2),
		.vld_out (cvld),
		.side_out(cside),
		.z_out   (cz)
	);

	// clamp to the first quadrant, then round half up to the angle grid
	always_comb begin
		priority if (cz[ZW-1]) begin
			zc = '0;
		end else if (cz > Z_MAX) begin
			zc = Z_MAX;
		end else begin
			zc = cz;
		end
		zr = (ZW'(zc) + (ZW'(1) << (ROUND_SHIFT - 1))) >> ROUND_SHIFT;
	end

	always_ff @(posedge clk) begin
		side_s3 <= cside;
		a_s3    <= zr[ANGLE_WIDTH-1:0];
	end

	// move into the right quadrant, fold 360 back to 0
	always_comb begin
		unique case (side_s3.quad)
			QUAD_PP: bq = {1'b0, a_s3};
			QUAD_NP: bq = DEG_180 - {1'b0, a_s3};
			QUAD_NN: bq = DEG_180 + {1'b0, a_s3};
			QUAD_PN: bq = DEG_360 - {1'b0, a_s3};
			default: bq = {1'b0, a_s3};
		endcase
		if (side_s3.spec) begin
			bw = {1'b0, side_s3.spec_bearing};
		end else if (bq >= DEG_360) begin
			bw = bq - DEG_360;
		end else begin
			bw = bq;
		end
	end

	always_ff @(posedge clk) begin
		bearing_s4 <= bw[ANGLE_WIDTH-1:0];
		heading_s4 <= side_s3.heading;
	end

	// wrap the difference once into [-180, 180]
	always_comb begin
		d0 = $signed((ANGLE_WIDTH + 2)'(bearing_s4)) - $signed((ANGLE_WIDTH + 2)'(heading_s4));
		priority if (d0 > D180) begin
			dw = d0 - D360;
		end else if (d0 < -D180) begin
			dw = d0 + D360;
		end else begin
			dw = d0;
		end
	end

	always_ff @(posedge clk) begin
		res_s5.bearing    <= bearing_s4;
		res_s5.turn_angle <= dw[ANGLE_WIDTH-1:0];
	end

	assign done   = vld_s5;
	assign result = res_s5;

endmodule

// ----- src/bta_checker.sv -----
// Port-level checker for the bearing and turn angle block, with its bind.
module bta_checker
	import bta_pkg::*;
#(
	parameter int LAT = 21
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input bta_item_t   item,
	input logic        busy,
	input logic        done,
	input bta_result_t result
);

	localparam int CW = $clog2(LAT + 1);

	logic [CW-1:0] warm_q;
	logic          warm;

	// count cycles since reset so history reaches back only over live ones
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CW'(LAT)) begin
			warm_q <= warm_q + CW'(1);
		end
	end

	assign warm = (warm_q == CW'(LAT));

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_one_result_per_word: assert property (@(posedge clk) disable iff (!arst_n)
		warm |-> (done == $past(start && !busy, LAT)))
		else $error("done does not follow accepted word by fixed latency");

	a_bearing_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.bearing < 16'd46080))
		else $error("bearing out of range");

	a_coincident_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(warm && done && $past(item.start_x == item.target_x && item.start_y == item.target_y,
		LAT)) |-> (result.bearing == '0))
		else $error("coincident points give nonzero bearing");

endmodule

bind bearing_and_turn_angle bta_checker #(
	.LAT(CORDIC_STEPS + 5)
) u_bta_checker (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.item  (item),
	.busy  (busy),
	.done  (done),
	.result(result)
);
